/* sv/rtpr_pkg.sv */
// ----------------------------------------------------------------------------
// rtpr_pkg
// Shared types and constants of the rtp reorder buffer: word layouts,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpr_pkg;

  // default store depth
  localparam int RTPR_CAPACITY = 64;

  // field widths
  localparam int RTPR_SEQ_W  = 16;
  localparam int RTPR_KEY_W  = 32;
  localparam int RTPR_TAG_W  = 32;
  localparam int RTPR_MARK_W = 6;
  localparam int RTPR_CFG_IDX_W = 4;
  localparam int RTPR_CFG_DAT_W = 16;

  // sequence numbers above this reload the hold counter
  localparam logic [RTPR_SEQ_W-1:0] RTPR_SEQ_HIGH = 16'd32768;

  // configuration register indexes
  localparam logic [RTPR_CFG_IDX_W-1:0] CFG_HIGH_WATER    = 4'd0;
  localparam logic [RTPR_CFG_IDX_W-1:0] CFG_LOW_WATER     = 4'd1;
  localparam logic [RTPR_CFG_IDX_W-1:0] CFG_WRAP_HOLD     = 4'd2;
  localparam logic [RTPR_CFG_IDX_W-1:0] CFG_LOW_SEQ_LIMIT = 4'd3;

  // configuration reset values
  localparam logic [RTPR_MARK_W-1:0] HIGH_WATER_RST    = 6'd60;
  localparam logic [RTPR_MARK_W-1:0] LOW_WATER_RST     = 6'd12;
  localparam logic [RTPR_SEQ_W-1:0]  WRAP_HOLD_RST     = 16'd500;
  localparam logic [RTPR_SEQ_W-1:0]  LOW_SEQ_LIMIT_RST = 16'd500;

  // input word
  typedef struct packed {
    logic [RTPR_SEQ_W-1:0] seq_number;
    logic [RTPR_TAG_W-1:0] packet_tag;
  } rtpr_in_t;

  // result word
  typedef struct packed {
    logic [RTPR_KEY_W-1:0] out_key;
    logic [RTPR_TAG_W-1:0] out_tag;
    logic                  last;
  } rtpr_out_t;

  // one store entry
  typedef struct packed {
    logic [RTPR_KEY_W-1:0] key;
    logic [RTPR_TAG_W-1:0] tag;
  } rtpr_entry_t;

  // configuration register set
  typedef struct packed {
    logic [RTPR_MARK_W-1:0] high_water;
    logic [RTPR_MARK_W-1:0] low_water;
    logic [RTPR_SEQ_W-1:0]  wrap_hold;
    logic [RTPR_SEQ_W-1:0]  low_seq_limit;
  } rtpr_cfg_t;

endpackage

`default_nettype wire

/* sv/rtpr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rtpr_cfg_regs
// Configuration register file; takes one write per cycle, bad indexes dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpr_cfg_regs
  import rtpr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [RTPR_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RTPR_CFG_DAT_W-1:0] cfg_data,
  output rtpr_cfg_t                      cfg
);

  // always able to take a word
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_water    <= HIGH_WATER_RST;
      cfg.low_water     <= LOW_WATER_RST;
      cfg.wrap_hold     <= WRAP_HOLD_RST;
      cfg.low_seq_limit <= LOW_SEQ_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HIGH_WATER:    cfg.high_water    <= cfg_data[RTPR_MARK_W-1:0];
        CFG_LOW_WATER:     cfg.low_water     <= cfg_data[RTPR_MARK_W-1:0];
        CFG_WRAP_HOLD:     cfg.wrap_hold     <= cfg_data;
        CFG_LOW_SEQ_LIMIT: cfg.low_seq_limit <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/rtpr_key_ext.sv */
// ----------------------------------------------------------------------------
// rtpr_key_ext
// Extends a 16-bit sequence number to a 32-bit key with a wrap hold counter
// and an epoch count; state advances on each step pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpr_key_ext
  import rtpr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [RTPR_SEQ_W-1:0] seq,
  input  wire logic [RTPR_SEQ_W-1:0] wrap_hold,
  input  wire logic [RTPR_SEQ_W-1:0] low_seq_limit,
  output logic      [RTPR_KEY_W-1:0] key
);

  logic [RTPR_SEQ_W-1:0] hold_count, hold_count_next;
  logic [RTPR_SEQ_W-1:0] epoch_base, epoch_base_next;
  logic [RTPR_SEQ_W-1:0] key_hi;

  // hold reload or countdown, epoch advance on expiry
  always_comb begin
    if (seq > RTPR_SEQ_HIGH) begin
      hold_count_next = wrap_hold;
    end else if (hold_count != '0) begin
      hold_count_next = hold_count - 1'b1;
    end else begin
      hold_count_next = '0;
    end
    if (hold_count_next == '0 && hold_count != '0) begin
      epoch_base_next = epoch_base + 1'b1;
    end else begin
      epoch_base_next = epoch_base;
    end
    // small numbers join the next epoch while the hold is active
    if (hold_count_next != '0 && seq < low_seq_limit) begin
      key_hi = epoch_base_next + 1'b1;
    end else begin
      key_hi = epoch_base_next;
    end
  end

  assign key = {key_hi, seq};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
      epoch_base <= '0;
    end else if (step) begin
      hold_count <= hold_count_next;
      epoch_base <= epoch_base_next;
    end
  end

endmodule

`default_nettype wire

/* sv/rtpr_store_mem.sv */
// ----------------------------------------------------------------------------
// rtpr_store_mem
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpr_store_mem
  import rtpr_pkg::*;
#(
  parameter int DEPTH = RTPR_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire rtpr_entry_t   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output rtpr_entry_t        rdata
);

  rtpr_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/rtp_reorder_buffer.sv */
// ----------------------------------------------------------------------------
// rtp_reorder_buffer
// RTP packet reorder buffer keyed by an extended 32-bit sequence number.
// ----------------------------------------------------------------------------
// Usage: present a packet word on cmd and raise start; it is taken at an edge
// where busy is low. The sequence number is extended to a 32-bit key and the
// key/tag pair is inserted into a sorted store (a duplicate key replaces the
// tag). When the fill passes the high mark, the smallest entries are released
// in ascending order on result, one per cycle with result_valid high for one
// cycle, and result.last marks the final word of the run. The receiver cannot
// stall; every word must be taken in the cycle it is shown.
// Steps per packet, all with busy high: a binary search over the fill, each step
// a read and a compare (at most ceil(log2(fill+1)) steps), then a closing search
// state; a new key then moves entries up one place each, read and write overlapped,
// and is written into the gap; a duplicate key is written in its last compare
// state instead. Then a check state and the drain state, which releases one entry
// per cycle. The search uses the single key comparator and memory port pair.
// Released words appear in the cycle after their reads; the last one is shown in
// the first cycle with busy low.
// Configuration is written through cfg_valid/cfg_ready; the user is to write it
// only while the block is idle, which the block itself does not enforce. Reset
// sets the registers to defaults and empties the store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_reorder_buffer
  import rtpr_pkg::*;
#(
  parameter int CAPACITY = RTPR_CAPACITY
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire rtpr_in_t                  cmd,
  output logic                           result_valid,
  output rtpr_out_t                      result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [RTPR_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RTPR_CFG_DAT_W-1:0] cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > RTPR_MARK_W) ? CW : RTPR_MARK_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  rtpr_cfg_t             cfg;
  logic [RTPR_KEY_W-1:0] ext_key;
  logic                  accept;

  logic [2:0]            state, state_next;
  logic [RTPR_KEY_W-1:0] key, key_next;
  logic [RTPR_TAG_W-1:0] tag, tag_next;
  logic [CW-1:0]         lo_b, lo_b_next, hi_b, hi_b_next, mid, mid_next;
  logic [CW-1:0]         j, j_next, jw, jw_next;
  logic                  pend, pend_next;
  logic [CW-1:0]         fill, fill_next;
  logic [AW-1:0]         head, head_next;
  logic [CW-1:0]         cnt, cnt_next, n_r, n_next;
  logic                  res_valid_next, res_last, res_last_next;

  logic [CW:0]           mid_sum;
  logic [CW-1:0]         rd_la, wr_la;
  logic [CW:0]           rd_sum, wr_sum;
  logic [AW-1:0]         rd_phys, wr_phys, head_inc;
  logic                  mem_re, mem_we;
  rtpr_entry_t           mem_wdata, mem_rdata;

  logic [MW-1:0]         hw_ext, lw_ext, cap_m1, hi_m, lo_m;
  logic [CW-1:0]         hi_eff, lo_eff;

  // configuration
  rtpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // key extension, advanced once per accepted packet
  assign accept = start && !busy;

  rtpr_key_ext u_key (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .seq           (cmd.seq_number),
    .wrap_hold     (cfg.wrap_hold),
    .low_seq_limit (cfg.low_seq_limit),
    .key           (ext_key)
  );

  // store
  rtpr_store_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_phys),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_phys),
    .rdata (mem_rdata)
  );

  // effective marks bounded by the store depth
  always_comb begin
    hw_ext = MW'(cfg.high_water);
    lw_ext = MW'(cfg.low_water);
    cap_m1 = MW'(CAPACITY - 1);
    hi_m   = (hw_ext > cap_m1) ? cap_m1 : hw_ext;
    lo_m   = (lw_ext > hi_m) ? hi_m : lw_ext;
    hi_eff = CW'(hi_m);
    lo_eff = CW'(lo_m);
  end

  // logical to physical index, ring starting at head
  always_comb begin
    rd_sum  = (CW+1)'(head) + (CW+1)'(rd_la);
    wr_sum  = (CW+1)'(head) + (CW+1)'(wr_la);
    rd_phys = (rd_sum >= (CW+1)'(CAPACITY)) ? AW'(rd_sum - (CW+1)'(CAPACITY))
                                            : AW'(rd_sum);
    wr_phys = (wr_sum >= (CW+1)'(CAPACITY)) ? AW'(wr_sum - (CW+1)'(CAPACITY))
                                            : AW'(wr_sum);
    head_inc = (rd_phys == AW'(CAPACITY - 1)) ? '0 : rd_phys + 1'b1;
  end

  assign mid_sum = (CW+1)'(lo_b) + (CW+1)'(hi_b);

  // sequencer: search, open gap, insert, drain
  always_comb begin
    state_next     = state;
    key_next       = key;
    tag_next       = tag;
    lo_b_next      = lo_b;
    hi_b_next      = hi_b;
    mid_next       = mid;
    j_next         = j;
    jw_next        = jw;
    pend_next      = pend;
    fill_next      = fill;
    head_next      = head;
    cnt_next       = cnt;
    n_next         = n_r;
    res_valid_next = 1'b0;
    res_last_next  = 1'b0;
    rd_la          = '0;
    wr_la          = '0;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = '{key: key, tag: tag};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          key_next   = ext_key;
          tag_next   = cmd.packet_tag;
          lo_b_next  = '0;
          hi_b_next  = fill;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_b < hi_b) begin
          mid_next   = CW'(mid_sum >> 1);
          rd_la      = CW'(mid_sum >> 1);
          mem_re     = 1'b1;
          state_next = S_CMP;
        end else begin
          j_next     = fill;
          pend_next  = 1'b0;
          state_next = S_SHIFT;
        end
      end
      S_CMP: begin
        // shared key comparator
        if (mem_rdata.key == key) begin
          wr_la      = mid;
          mem_we     = 1'b1;
          state_next = S_CHECK;
        end else begin
          if (mem_rdata.key < key) begin
            lo_b_next = mid + 1'b1;
          end else begin
            hi_b_next = mid;
          end
          state_next = S_SRCH;
        end
      end
      S_SHIFT: begin
        // move entries up one place, read and write overlapped
        if (pend) begin
          wr_la     = jw;
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
        end
        if (j > lo_b) begin
          rd_la     = j - 1'b1;
          mem_re    = 1'b1;
          jw_next   = j;
          j_next    = j - 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            wr_la      = lo_b;
            mem_we     = 1'b1;
            fill_next  = fill + 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (fill > hi_eff) begin
          n_next     = fill - lo_eff;
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DRAIN: begin
        rd_la          = cnt;
        mem_re         = 1'b1;
        res_valid_next = 1'b1;
        cnt_next       = cnt + 1'b1;
        if (cnt + 1'b1 == n_r) begin
          res_last_next = 1'b1;
          head_next     = head_inc;
          fill_next     = lo_eff;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      head         <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
      res_last     <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      head         <= head_next;
      pend         <= pend_next;
      result_valid <= res_valid_next;
      res_last     <= res_last_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    key  <= key_next;
    tag  <= tag_next;
    lo_b <= lo_b_next;
    hi_b <= hi_b_next;
    mid  <= mid_next;
    j    <= j_next;
    jw   <= jw_next;
    cnt  <= cnt_next;
    n_r  <= n_next;
  end

  assign busy           = (state != S_IDLE);
  assign result.out_key = mem_rdata.key;
  assign result.out_tag = mem_rdata.tag;
  assign result.last    = res_last;

  // store never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill above capacity");

  // released words only come from a drain run
  a_res_from_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_DRAIN))
    else $error("result without drain");

  // a run ends at the last word and leaves the fill at the low mark
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> (!busy && fill == lo_eff))
    else $error("drain run ended badly");

  // an accepted packet always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accept did not start work");

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives RTP packet words into rtp_reorder_buffer and checks every released
// word against an in-bench model of the sequence extension and sorted store.
// Covers default marks, full-store drains, a zero high mark, a low mark above
// the high mark, a zero wrap hold and ignored register writes.
// ----------------------------------------------------------------------------

module testbench
  import rtpr_pkg::*;
();

  // register index outside the implemented set
  localparam logic [RTPR_CFG_IDX_W-1:0] CFG_IDX_TOP = 4'hF;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  rtpr_in_t                  cmd = '0;
  logic                      result_valid;
  rtpr_out_t                 result;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [RTPR_CFG_IDX_W-1:0] cfg_index = '0;
  logic [RTPR_CFG_DAT_W-1:0] cfg_data = '0;

  rtp_reorder_buffer DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  rtpr_cfg_t   cfg_model = '{high_water: HIGH_WATER_RST, low_water: LOW_WATER_RST,
                             wrap_hold: WRAP_HOLD_RST, low_seq_limit: LOW_SEQ_LIMIT_RST};
  logic [15:0] hold_cnt = '0;
  logic [15:0] epoch = '0;
  rtpr_entry_t store_q[$];

  rtpr_in_t    packet_q[$];
  rtpr_out_t   due_q[$];
  rtpr_out_t   want;
  int          fail_count = 0;

  // sender pacing
  int          burst_left = 8;
  int          gap_left = 0;
  bit          drain_wait = 1'b0;

  // stream generator state
  logic [15:0] stream_seq = '0;
  logic [15:0] last_seq = '0;

  // extend the number, insert into the sorted store, queue any released words
  function automatic void predict_release(input rtpr_in_t w);
    logic [15:0] seq;
    logic [31:0] key;
    bit          was_active;
    int          pos, hi, lo, n, i;
    rtpr_entry_t entry;
    rtpr_out_t   word;
    seq = w.seq_number;
    was_active = (hold_cnt != 0);
    if (seq > RTPR_SEQ_HIGH) begin
      hold_cnt = cfg_model.wrap_hold;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 16'd1;
    end
    key = {16'h0, seq};
    if (hold_cnt != 0) begin
      if (seq < cfg_model.low_seq_limit) key = key + 32'h0001_0000;
    end else if (was_active) begin
      epoch = epoch + 16'd1;
    end
    key = key + {epoch, 16'h0};

    pos = 0;
    while (pos < store_q.size() && store_q[pos].key < key) pos++;
    if (pos < store_q.size() && store_q[pos].key == key) begin
      store_q[pos].tag = w.packet_tag;
    end else if (store_q.size() < RTPR_CAPACITY) begin
      entry.key = key;
      entry.tag = w.packet_tag;
      store_q.insert(pos, entry);
    end

    // marks clamped to the store size
    hi = cfg_model.high_water;
    if (hi > RTPR_CAPACITY - 1) hi = RTPR_CAPACITY - 1;
    lo = cfg_model.low_water;
    if (lo > hi) lo = hi;
    if (store_q.size() > hi) begin
      n = store_q.size() - lo;
      for (i = 0; i < n; i++) begin
        entry = store_q.pop_front();
        word.out_key = entry.key;
        word.out_tag = entry.tag;
        word.last = (i == n - 1);
        due_q.insert(due_q.size(), word);
      end
    end
  endfunction

  // driver: bursts of packets with random gaps and occasional drain pauses
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_release(cmd);
      if (!(start && busy)) begin
        if (drain_wait && due_q.size() == 0 && !busy) drain_wait = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (drain_wait || packet_q.size() == 0) begin
          start <= 1'b0;
        end else begin
          cmd <= packet_q.pop_front();
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 150)
                                                    : $urandom_range(0, 4);
            drain_wait = ($urandom_range(0, 7) == 0);
          end
        end
      end
    end
  end

  // monitor: every released word against the oldest expected one
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (due_q.size() == 0) begin
        $error("unexpected word: out_key %h out_tag %h", result.out_key, result.out_tag);
        fail_count++;
      end else begin
        want = due_q.pop_front();
        if (result.out_key !== want.out_key) begin
          $error("out_key expected %h actual %h", want.out_key, result.out_key);
          fail_count++;
        end
        if (result.out_tag !== want.out_tag) begin
          $error("out_tag expected %h actual %h", want.out_tag, result.out_tag);
          fail_count++;
        end
        if (result.last !== want.last) begin
          $error("last expected %b actual %b", want.last, result.last);
          fail_count++;
        end
      end
    end
  end

  function automatic void add_packet(input logic [15:0] seq, input logic [31:0] tag);
    rtpr_in_t w;
    w.seq_number = seq;
    w.packet_tag = tag;
    packet_q.insert(packet_q.size(), w);
    last_seq = seq;
  endfunction

  // mostly an in-order stream with jitter, plus repeats and random noise
  function automatic void queue_stream(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: add_packet(16'($urandom), $urandom);
        1: add_packet(last_seq, $urandom);
        default: begin
          stream_seq = stream_seq + 16'd1;
          add_packet(stream_seq + 16'($urandom_range(0, 8)) - 16'd4, $urandom);
        end
      endcase
    end
  endfunction

  function automatic void seed_stream();
    stream_seq = $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 40))
                                      : 16'($urandom);
  endfunction

  task automatic write_reg(input logic [RTPR_CFG_IDX_W-1:0] idx,
                           input logic [RTPR_CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HIGH_WATER:    cfg_model.high_water = value[RTPR_MARK_W-1:0];
      CFG_LOW_WATER:     cfg_model.low_water = value[RTPR_MARK_W-1:0];
      CFG_WRAP_HOLD:     cfg_model.wrap_hold = value;
      CFG_LOW_SEQ_LIMIT: cfg_model.low_seq_limit = value;
      default: ;
    endcase
  endtask

  // idle means nothing queued, nothing in flight and nothing expected
  task automatic wait_idle(input int limit);
    int quiet, spent;
    quiet = 0;
    spent = 0;
    while (quiet < 8 && spent < limit) begin
      @(posedge clk);
      spent++;
      if (packet_q.size() == 0 && !start && !busy && due_q.size() == 0) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic run_phase(input logic [15:0] hw, input logic [15:0] lw,
                           input logic [15:0] hold, input logic [15:0] limit,
                           input int count);
    write_reg(CFG_HIGH_WATER, hw);
    write_reg(CFG_LOW_WATER, lw);
    write_reg(CFG_WRAP_HOLD, hold);
    write_reg(CFG_LOW_SEQ_LIMIT, limit);
    @(negedge clk);
    seed_stream();
    queue_stream(count);
    wait_idle(200000);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // edge numbers at the default marks: wrap reload, limit boundary,
    // moved small numbers and duplicate keys
    add_packet(16'd0, 32'h0000_0000);
    add_packet(16'hFFFF, 32'hFFFF_FFFF);
    add_packet(16'd1, 32'h0000_0001);
    add_packet(16'd499, 32'hAAAA_AAAA);
    add_packet(16'd500, 32'h5555_5555);
    add_packet(16'd1, 32'h1234_5678);
    add_packet(16'd32768, 32'h0000_0000);
    add_packet(16'd32769, 32'hFFFF_FFFF);
    add_packet(16'd0, 32'h0000_0001);
    add_packet(16'hFFFF, 32'h0000_0002);
    add_packet(16'h5555, 32'h0000_0003);
    add_packet(16'hAAAA, 32'h0000_0004);
    seed_stream();
    queue_stream(60);
    wait_idle(200000);

    // full store drained to empty, short hold so epochs advance
    run_phase(16'd63, 16'd0, 16'd20, 16'hFFFF, 70);
    // zero high mark and zero wrap hold, ignored writes in between
    write_reg(4'($urandom_range(4, 15)), 16'($urandom));
    write_reg(CFG_IDX_TOP, 16'hFFFF);
    run_phase(16'd0, 16'd5, 16'd0, 16'd40000, 30);
    // low mark above high mark, nothing moved to the next epoch
    run_phase(16'd5, 16'd62, 16'd3, 16'd0, 40);
    // longest hold
    run_phase(16'd10, 16'd2, 16'hFFFF, 16'd1000, 40);
    // random settings
    run_phase(16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)),
              16'($urandom_range(0, 40)), 16'($urandom), 30);
    run_phase(16'($urandom_range(0, 63)), 16'($urandom_range(0, 63)),
              16'($urandom_range(1, 300)), 16'($urandom), 30);

    wait_idle(200000);
    repeat (20) @(posedge clk);
    if (due_q.size() != 0) begin
      $error("%0d expected words never released", due_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("rtp_reorder_buffer verification clean");
    end else begin
      $display("rtp_reorder_buffer verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("rtp_reorder_buffer verification failed");
    $finish;
  end

endmodule
